/* rtl/core/nmae_pkg.sv */
`default_nettype none
package nmae_pkg;

  localparam int unsigned MAX_FRAME_PIXELS_DEF = 1048576;
  localparam int unsigned ANGLE_MAX_Q8         = 46080;
  localparam int unsigned CORDIC_STEPS         = 23;
  localparam int unsigned SQRT_STEPS           = 31;
  localparam int unsigned DIV_STEPS            = 8;
  localparam int unsigned FRONT_STAGES         = 4;
  localparam logic [15:0] CAP_RESET            = 16'd2560;
  // 180 degrees in Q16
  localparam int          HALF_TURN_Q16        = 11796480;

  typedef enum logic [2:0] {
    CLS_BOTH_EMPTY = 3'd0,
    CLS_GUESS_ONLY = 3'd1,
    CLS_TRUTH_ONLY = 3'd2,
    CLS_INLIER     = 3'd3,
    CLS_OUTLIER    = 3'd4
  } pix_class_t;

  typedef struct packed {
    logic no_truth;
    logic no_guess;
    logic last;
  } tag_t;

  typedef struct packed {
    tag_t        tag;
    logic        dneg;
    logic [17:0] dabs;
    logic [35:0] c2;
  } front_t;

  typedef struct packed {
    tag_t        tag;
    logic        dneg;
    logic [17:0] dabs;
    logic [30:0] root;
  } sqrt_t;

  typedef struct packed {
    tag_t               tag;
    logic               dneg;
    logic signed [25:0] z;
  } cord_t;

  typedef struct packed {
    tag_t        tag;
    logic [15:0] angle;
    logic [7:0]  grey;
  } grade_t;

  // atan(2^-i) in degrees, Q16
  function automatic logic [21:0] atan_q16(input int unsigned i);
    logic [21:0] v;
    case (i)
      0:       v = 22'd2949120;
      1:       v = 22'd1740967;
      2:       v = 22'd919879;
      3:       v = 22'd466945;
      4:       v = 22'd234379;
      5:       v = 22'd117304;
      6:       v = 22'd58666;
      7:       v = 22'd29335;
      8:       v = 22'd14668;
      9:       v = 22'd7334;
      10:      v = 22'd3667;
      11:      v = 22'd1833;
      12:      v = 22'd917;
      13:      v = 22'd458;
      14:      v = 22'd229;
      15:      v = 22'd115;
      16:      v = 22'd57;
      17:      v = 22'd29;
      18:      v = 22'd14;
      19:      v = 22'd7;
      20:      v = 22'd4;
      21:      v = 22'd2;
      22:      v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/nmae_if.sv */
`default_nettype none
interface nmae_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] truth_red;
  logic [7:0] truth_green;
  logic [7:0] truth_blue;
  logic [7:0] guess_red;
  logic [7:0] guess_green;
  logic [7:0] guess_blue;
  logic       last_pixel;

  modport source (output valid, truth_red, truth_green, truth_blue,
                  guess_red, guess_green, guess_blue, last_pixel, input ready);
  modport sink (input valid, truth_red, truth_green, truth_blue,
                guess_red, guess_green, guess_blue, last_pixel, output ready);
endinterface

interface nmae_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pixel_red;
  logic [7:0]  pixel_green;
  logic [7:0]  pixel_blue;
  logic [2:0]  pixel_class;
  logic [15:0] angle_deg_q8;
  logic [20:0] inlier_total;
  logic [20:0] outlier_total;
  logic [35:0] inlier_error_total;
  logic        frame_end;

  modport source (output valid, pixel_red, pixel_green, pixel_blue, pixel_class,
                  angle_deg_q8, inlier_total, outlier_total, inlier_error_total,
                  frame_end, input ready);
  modport sink (input valid, pixel_red, pixel_green, pixel_blue, pixel_class,
                angle_deg_q8, inlier_total, outlier_total, inlier_error_total,
                frame_end, output ready);
endinterface
`default_nettype wire

/* rtl/core/nmae_front.sv */
`default_nettype none
module nmae_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      t_r_i,
  input  wire logic [7:0]      t_g_i,
  input  wire logic [7:0]      t_b_i,
  input  wire logic [7:0]      g_r_i,
  input  wire logic [7:0]      g_g_i,
  input  wire logic [7:0]      g_b_i,
  input  wire logic            last_i,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output nmae_pkg::front_t     out_data
);

  localparam int N = nmae_pkg::FRONT_STAGES;

  logic [N-1:0] v_r;
  logic [N:0]   rdy;

  // stage ready chain: a stage loads when empty or when its successor moves
  assign rdy[N] = out_ready;
  for (genvar k = 0; k < N; k++) begin : g_rdy
    assign rdy[k] = !v_r[k] || rdy[k+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = v_r[N-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (rdy[k]) v_r[k] <= (k == 0) ? in_valid : v_r[k-1];
      end
    end
  end

  // decode components
  logic signed [9:0] tx10, ty10, gx10, gy10;
  logic signed [8:0] t0, t1, t2, g0, g1, g2;
  assign tx10 = $signed({1'b0, t_r_i, 1'b0}) - 10'sd255;
  assign ty10 = $signed({1'b0, t_g_i, 1'b0}) - 10'sd255;
  assign gx10 = $signed({1'b0, g_r_i, 1'b0}) - 10'sd255;
  assign gy10 = $signed({1'b0, g_g_i, 1'b0}) - 10'sd255;
  assign t0 = tx10[8:0];
  assign t1 = ty10[8:0];
  assign t2 = $signed({1'b0, t_b_i});
  assign g0 = gx10[8:0];
  assign g1 = gy10[8:0];
  assign g2 = $signed({1'b0, g_b_i});

  // stage 0: component products
  logic signed [17:0] p_r [9];
  nmae_pkg::tag_t     tag0_r, tag1_r, tag2_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      p_r[0] <= t0 * g0;
      p_r[1] <= t1 * g1;
      p_r[2] <= t2 * g2;
      p_r[3] <= t1 * g2;
      p_r[4] <= t2 * g1;
      p_r[5] <= t2 * g0;
      p_r[6] <= t0 * g2;
      p_r[7] <= t0 * g1;
      p_r[8] <= t1 * g0;
      tag0_r.no_truth <= (t_r_i | t_g_i | t_b_i) == 8'd0;
      tag0_r.no_guess <= (g_r_i | g_g_i | g_b_i) == 8'd0;
      tag0_r.last     <= last_i;
    end
  end

  // stage 1: dot product and cross product
  logic signed [18:0] dot;
  logic signed [18:0] cx19, cy19, cz19;
  logic signed [17:0] cx_r, cy_r, cz_r;
  logic               dneg1_r;
  logic [17:0]        dabs1_r;
  logic [18:0]        dmag;

  assign dot  = 19'(p_r[0]) + 19'(p_r[1]) + 19'(p_r[2]);
  assign cx19 = 19'(p_r[3]) - 19'(p_r[4]);
  assign cy19 = 19'(p_r[5]) - 19'(p_r[6]);
  assign cz19 = 19'(p_r[7]) - 19'(p_r[8]);
  assign dmag = dot[18] ? 19'(-dot) : dot;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      cx_r    <= cx19[17:0];
      cy_r    <= cy19[17:0];
      cz_r    <= cz19[17:0];
      dneg1_r <= dot[18];
      dabs1_r <= dmag[17:0];
      tag1_r  <= tag0_r;
    end
  end

  // stage 2: squares of the cross product
  logic signed [35:0] sqx, sqy, sqz;
  logic [33:0]        sx_r, sy_r, sz_r;
  logic               dneg2_r;
  logic [17:0]        dabs2_r;

  assign sqx = cx_r * cx_r;
  assign sqy = cy_r * cy_r;
  assign sqz = cz_r * cz_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      sx_r    <= sqx[33:0];
      sy_r    <= sqy[33:0];
      sz_r    <= sqz[33:0];
      dneg2_r <= dneg1_r;
      dabs2_r <= dabs1_r;
      tag2_r  <= tag1_r;
    end
  end

  // stage 3: squared cross magnitude
  nmae_pkg::front_t o_r;
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      o_r.c2   <= 36'(sx_r) + 36'(sy_r) + 36'(sz_r);
      o_r.dneg <= dneg2_r;
      o_r.dabs <= dabs2_r;
      o_r.tag  <= tag2_r;
    end
  end

  assign out_data = o_r;

endmodule
`default_nettype wire

/* rtl/core/nmae_sqrt.sv */
`default_nettype none
module nmae_sqrt (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire nmae_pkg::front_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output nmae_pkg::sqrt_t       out_data
);

  localparam int N = nmae_pkg::SQRT_STEPS;

  logic [N-1:0]   v_r;
  logic [N:0]     rdy;
  nmae_pkg::tag_t tag_r  [N];
  logic           dneg_r [N];
  logic [17:0]    dabs_r [N];
  logic [61:0]    rad_r  [N];
  logic [32:0]    rem_r  [N];
  logic [30:0]    root_r [N];

  assign rdy[N] = out_ready;
  for (genvar k = 0; k < N; k++) begin : g_rdy
    assign rdy[k] = !v_r[k] || rdy[k+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = v_r[N-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (rdy[k]) v_r[k] <= (k == 0) ? in_valid : v_r[k-1];
      end
    end
  end

  // one root bit per stage, two radicand bits consumed each time
  for (genvar k = 0; k < N; k++) begin : g_stage
    nmae_pkg::tag_t tag_i;
    logic           dneg_i;
    logic [17:0]    dabs_i;
    logic [61:0]    rad_i;
    logic [32:0]    rem_i;
    logic [30:0]    root_i;
    logic [34:0]    cur;
    logic [34:0]    trial;
    logic           take;

    if (k == 0) begin : g_first
      assign tag_i  = in_data.tag;
      assign dneg_i = in_data.dneg;
      assign dabs_i = in_data.dabs;
      assign rad_i  = {in_data.c2, 26'd0};
      assign rem_i  = '0;
      assign root_i = '0;
    end else begin : g_next
      assign tag_i  = tag_r[k-1];
      assign dneg_i = dneg_r[k-1];
      assign dabs_i = dabs_r[k-1];
      assign rad_i  = rad_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
    end

    assign cur   = {rem_i, rad_i[61:60]};
    assign trial = {2'b00, root_i, 2'b01};
    assign take  = cur >= trial;

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        tag_r[k]  <= tag_i;
        dneg_r[k] <= dneg_i;
        dabs_r[k] <= dabs_i;
        rad_r[k]  <= {rad_i[59:0], 2'b00};
        rem_r[k]  <= take ? 33'(cur - trial) : cur[32:0];
        root_r[k] <= {root_i[29:0], take};
      end
    end
  end

  assign out_data.tag  = tag_r[N-1];
  assign out_data.dneg = dneg_r[N-1];
  assign out_data.dabs = dabs_r[N-1];
  assign out_data.root = root_r[N-1];

endmodule
`default_nettype wire

/* rtl/core/nmae_cordic.sv */
`default_nettype none
module nmae_cordic (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire nmae_pkg::sqrt_t in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output nmae_pkg::cord_t      out_data
);

  localparam int N = nmae_pkg::CORDIC_STEPS;

  logic [N-1:0]       v_r;
  logic [N:0]         rdy;
  nmae_pkg::tag_t     tag_r  [N];
  logic               dneg_r [N];
  logic signed [35:0] x_r    [N];
  logic signed [35:0] y_r    [N];
  logic signed [25:0] z_r    [N];

  assign rdy[N] = out_ready;
  for (genvar k = 0; k < N; k++) begin : g_rdy
    assign rdy[k] = !v_r[k] || rdy[k+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = v_r[N-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (rdy[k]) v_r[k] <= (k == 0) ? in_valid : v_r[k-1];
      end
    end
  end

  // one vectoring rotation per stage, driving y toward zero
  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic signed [25:0] ATAN = 26'(nmae_pkg::atan_q16(k));
    nmae_pkg::tag_t     tag_i;
    logic               dneg_i;
    logic signed [35:0] x_i, y_i, dx, dy;
    logic signed [25:0] z_i;
    logic               ypos, yneg;

    if (k == 0) begin : g_first
      assign tag_i  = in_data.tag;
      assign dneg_i = in_data.dneg;
      assign x_i    = $signed({5'd0, in_data.dabs, 13'd0});
      assign y_i    = $signed({5'd0, in_data.root});
      assign z_i    = '0;
    end else begin : g_next
      assign tag_i  = tag_r[k-1];
      assign dneg_i = dneg_r[k-1];
      assign x_i    = x_r[k-1];
      assign y_i    = y_r[k-1];
      assign z_i    = z_r[k-1];
    end

    assign dx   = y_i >>> k;
    assign dy   = x_i >>> k;
    assign yneg = y_i[35];
    assign ypos = !y_i[35] && (y_i != '0);

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        tag_r[k]  <= tag_i;
        dneg_r[k] <= dneg_i;
        if (ypos) begin
          x_r[k] <= x_i + dx;
          y_r[k] <= y_i - dy;
          z_r[k] <= z_i + ATAN;
        end else if (yneg) begin
          x_r[k] <= x_i - dx;
          y_r[k] <= y_i + dy;
          z_r[k] <= z_i - ATAN;
        end else begin
          x_r[k] <= x_i;
          y_r[k] <= y_i;
          z_r[k] <= z_i;
        end
      end
    end
  end

  assign out_data.tag  = tag_r[N-1];
  assign out_data.dneg = dneg_r[N-1];
  assign out_data.z    = z_r[N-1];

endmodule
`default_nettype wire

/* rtl/core/nmae_grade.sv */
`default_nettype none
module nmae_grade (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [15:0]     cap,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire nmae_pkg::cord_t in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output nmae_pkg::grade_t     out_data
);

  localparam int D = nmae_pkg::DIV_STEPS;
  localparam int N = D + 1;

  logic [N-1:0]   v_r;
  logic [N:0]     rdy;
  nmae_pkg::tag_t tag_r [N];
  logic [15:0]    ang_r [N];
  logic [23:0]    rem_r [N];
  logic [D-1:0]   quo_r [N];
  logic           sat_r [N];

  assign rdy[N] = out_ready;
  for (genvar k = 0; k < N; k++) begin : g_rdy
    assign rdy[k] = !v_r[k] || rdy[k+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = v_r[N-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (rdy[k]) v_r[k] <= (k == 0) ? in_valid : v_r[k-1];
      end
    end
  end

  // stage 0: fold the obtuse case, round to Q8.8, clamp
  logic signed [27:0] zf;
  logic [26:0]        zr;
  logic [18:0]        q;
  logic [15:0]        ang;
  logic [23:0]        num;

  assign zf  = in_data.dneg ? 28'(nmae_pkg::HALF_TURN_Q16) - 28'(in_data.z)
                            : 28'(in_data.z);
  assign zr  = zf[27] ? 27'd0 : zf[26:0] + 27'd128;
  assign q   = zr[26:8];
  assign ang = (q > 19'(nmae_pkg::ANGLE_MAX_Q8)) ? 16'(nmae_pkg::ANGLE_MAX_Q8) : q[15:0];
  assign num = {ang, 8'd0} - 24'(ang);

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      tag_r[0] <= in_data.tag;
      ang_r[0] <= ang;
      rem_r[0] <= num;
      quo_r[0] <= '0;
      sat_r[0] <= num >= {cap, 8'd0};
    end
  end

  // grey quotient, one bit per stage, most significant first
  for (genvar j = 1; j < N; j++) begin : g_div
    localparam int B = D - j;
    logic [23:0] dv;
    logic        take;
    assign dv   = 24'(cap) << B;
    assign take = rem_r[j-1] >= dv;

    always_ff @(posedge clk) begin
      if (rdy[j]) begin
        tag_r[j] <= tag_r[j-1];
        ang_r[j] <= ang_r[j-1];
        sat_r[j] <= sat_r[j-1];
        rem_r[j] <= take ? rem_r[j-1] - dv : rem_r[j-1];
        quo_r[j] <= quo_r[j-1] | (D'(take) << B);
      end
    end
  end

  assign out_data.tag   = tag_r[N-1];
  assign out_data.angle = ang_r[N-1];
  assign out_data.grey  = sat_r[N-1] ? 8'd255 : 8'(quo_r[N-1]);

endmodule
`default_nettype wire

/* rtl/core/normal_map_angular_error.sv */
`default_nettype none
// Normal map angular error.
// in_port carries one pixel request per cycle when ready is high: truth and
// guessed normals as 8-bit RGB plus last_pixel. out_port returns one result
// per request, in order: display colour, class, angle in Q8.8 degrees,
// running frame totals and frame_end. cfg_we/cfg_wdata write the inlier
// angle cap (Q8.8 degrees); write it only while no request is in flight.
// Throughput is one pixel per cycle while out_port is not stalled. A request
// passes 4 product stages, 31 square-root stages (one root bit each), 23
// CORDIC stages, 9 rounding and grey-division stages, and the output
// register where the frame totals are updated.
// Reset empties the pipeline, clears the totals and sets the cap to
// 10.0 degrees. When the receiver stalls, the output holds and the pipeline
// keeps filling empty stages; in_port.ready drops only once every stage
// holds a request. Totals clear after the request marked last_pixel.
module normal_map_angular_error #(
  parameter int unsigned MAX_FRAME_PIXELS = nmae_pkg::MAX_FRAME_PIXELS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  nmae_in_if.sink     in_port,
  nmae_out_if.source  out_port,
  input  wire logic   cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  localparam longint unsigned SUM_LIMIT =
    longint'(MAX_FRAME_PIXELS) * longint'(nmae_pkg::ANGLE_MAX_Q8);
  localparam int CNT_W = $clog2(longint'(MAX_FRAME_PIXELS) + 1);
  localparam int SUM_W = $clog2(SUM_LIMIT + 1);

  // cap register
  logic [15:0] cap_r;
  always_ff @(posedge clk) begin
    if (!rst_n) cap_r <= nmae_pkg::CAP_RESET;
    else if (cfg_we) cap_r <= cfg_wdata;
  end

  // pipeline sections
  logic             f_v, f_rdy, s_v, s_rdy, c_v, c_rdy, g_v, g_rdy;
  nmae_pkg::front_t f_d;
  nmae_pkg::sqrt_t  s_d;
  nmae_pkg::cord_t  c_d;
  nmae_pkg::grade_t g_d;

  nmae_front u_front (
    .clk, .rst_n,
    .in_valid (in_port.valid), .in_ready (in_port.ready),
    .t_r_i (in_port.truth_red), .t_g_i (in_port.truth_green),
    .t_b_i (in_port.truth_blue), .g_r_i (in_port.guess_red),
    .g_g_i (in_port.guess_green), .g_b_i (in_port.guess_blue),
    .last_i (in_port.last_pixel),
    .out_valid (f_v), .out_ready (f_rdy), .out_data (f_d)
  );

  nmae_sqrt u_sqrt (
    .clk, .rst_n, .in_valid (f_v), .in_ready (f_rdy), .in_data (f_d),
    .out_valid (s_v), .out_ready (s_rdy), .out_data (s_d)
  );

  nmae_cordic u_cordic (
    .clk, .rst_n, .in_valid (s_v), .in_ready (s_rdy), .in_data (s_d),
    .out_valid (c_v), .out_ready (c_rdy), .out_data (c_d)
  );

  nmae_grade u_grade (
    .clk, .rst_n, .cap (cap_r), .in_valid (c_v), .in_ready (c_rdy), .in_data (c_d),
    .out_valid (g_v), .out_ready (g_rdy), .out_data (g_d)
  );

  // classify
  nmae_pkg::pix_class_t cls;
  always_comb begin
    if (g_d.tag.no_truth) begin
      cls = g_d.tag.no_guess ? nmae_pkg::CLS_BOTH_EMPTY : nmae_pkg::CLS_GUESS_ONLY;
    end else if (g_d.tag.no_guess) begin
      cls = nmae_pkg::CLS_TRUTH_ONLY;
    end else if (g_d.angle <= cap_r) begin
      cls = nmae_pkg::CLS_INLIER;
    end else begin
      cls = nmae_pkg::CLS_OUTLIER;
    end
  end

  // frame totals
  logic [CNT_W-1:0] in_cnt_r, out_cnt_r, in_cnt_nxt, out_cnt_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [SUM_W:0]   sum_add;
  logic             is_in, is_out;

  assign is_in   = cls == nmae_pkg::CLS_INLIER;
  assign is_out  = (cls == nmae_pkg::CLS_OUTLIER) || (cls == nmae_pkg::CLS_TRUTH_ONLY);
  assign sum_add = (SUM_W+1)'(sum_r) + (SUM_W+1)'(g_d.angle);

  always_comb begin
    in_cnt_nxt  = in_cnt_r;
    out_cnt_nxt = out_cnt_r;
    sum_nxt     = sum_r;
    if (is_in) begin
      if (in_cnt_r < CNT_W'(MAX_FRAME_PIXELS)) in_cnt_nxt = in_cnt_r + 1'b1;
      sum_nxt = (sum_add > (SUM_W+1)'(SUM_LIMIT)) ? SUM_W'(SUM_LIMIT) : sum_add[SUM_W-1:0];
    end
    if (is_out && out_cnt_r < CNT_W'(MAX_FRAME_PIXELS)) out_cnt_nxt = out_cnt_r + 1'b1;
  end

  // output register
  logic        o_v_r, o_load;
  logic [7:0]  o_red_r, o_green_r, o_blue_r;
  logic [2:0]  o_cls_r;
  logic [15:0] o_ang_r;
  logic [63:0] o_in_r, o_out_r, o_sum_r;
  logic        o_end_r;

  assign g_rdy  = !o_v_r || out_port.ready;
  assign o_load = g_rdy && g_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r     <= 1'b0;
      in_cnt_r  <= '0;
      out_cnt_r <= '0;
      sum_r     <= '0;
    end else begin
      if (g_rdy) o_v_r <= g_v;
      if (o_load) begin
        in_cnt_r  <= g_d.tag.last ? '0 : in_cnt_nxt;
        out_cnt_r <= g_d.tag.last ? '0 : out_cnt_nxt;
        sum_r     <= g_d.tag.last ? '0 : sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      o_cls_r <= cls;
      o_end_r <= g_d.tag.last;
      o_in_r  <= 64'(in_cnt_nxt);
      o_out_r <= 64'(out_cnt_nxt);
      o_sum_r <= 64'(sum_nxt);
      case (cls)
        nmae_pkg::CLS_BOTH_EMPTY: begin
          {o_red_r, o_green_r, o_blue_r} <= {8'd0, 8'd0, 8'd255};
          o_ang_r <= '0;
        end
        nmae_pkg::CLS_GUESS_ONLY: begin
          {o_red_r, o_green_r, o_blue_r} <= {8'd0, 8'd255, 8'd0};
          o_ang_r <= '0;
        end
        nmae_pkg::CLS_TRUTH_ONLY: begin
          {o_red_r, o_green_r, o_blue_r} <= {8'd255, 8'd0, 8'd0};
          o_ang_r <= '0;
        end
        default: begin
          {o_red_r, o_green_r, o_blue_r} <= {g_d.grey, g_d.grey, g_d.grey};
          o_ang_r <= g_d.angle;
        end
      endcase
    end
  end

  assign out_port.valid              = o_v_r;
  assign out_port.pixel_red          = o_red_r;
  assign out_port.pixel_green        = o_green_r;
  assign out_port.pixel_blue         = o_blue_r;
  assign out_port.pixel_class        = o_cls_r;
  assign out_port.angle_deg_q8       = o_ang_r;
  assign out_port.inlier_total       = o_in_r[20:0];
  assign out_port.outlier_total      = o_out_r[20:0];
  assign out_port.inlier_error_total = o_sum_r[35:0];
  assign out_port.frame_end          = o_end_r;

endmodule
`default_nettype wire

/* rtl/core/nmae_checker.sv */
`default_nettype none
module nmae_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  pixel_red,
  input wire logic [7:0]  pixel_green,
  input wire logic [7:0]  pixel_blue,
  input wire logic [2:0]  pixel_class,
  input wire logic [15:0] angle_deg_q8
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pixel_class) && $stable(angle_deg_q8))
    else $error("stalled result changed");

  // reset empties the output
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // empty pairs show a fixed colour and no angle
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && pixel_class == nmae_pkg::CLS_BOTH_EMPTY |->
      pixel_blue == 8'd255 && pixel_red == 8'd0 && pixel_green == 8'd0 &&
      angle_deg_q8 == 16'd0)
    else $error("empty pair colour wrong");

  // measured pairs show grey
  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (pixel_class == nmae_pkg::CLS_INLIER ||
                  pixel_class == nmae_pkg::CLS_OUTLIER) |->
      pixel_red == pixel_green && pixel_green == pixel_blue)
    else $error("measured pair not grey");

endmodule

bind normal_map_angular_error nmae_checker u_nmae_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_port.valid),
  .out_ready    (out_port.ready),
  .pixel_red    (out_port.pixel_red),
  .pixel_green  (out_port.pixel_green),
  .pixel_blue   (out_port.pixel_blue),
  .pixel_class  (out_port.pixel_class),
  .angle_deg_q8 (out_port.angle_deg_q8)
);
`default_nettype wire

/* tb/tb_normal_map_angular_error.sv */
`default_nettype none
module tb_normal_map_angular_error;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          LIMIT_CYCLES = 400000;
  localparam int          DRAIN_CYCLES = 80;
  localparam longint      PIXEL_SAT    = 64'd1048576;
  localparam longint      SUM_SAT      = 64'd1048576 * 64'd46080;

  typedef struct packed {
    logic [7:0] tr, tg, tb, gr, gg, gb;
    logic       last;
  } pair_t;

  typedef struct packed {
    logic [7:0]  red, green, blue;
    logic [2:0]  cls;
    logic [15:0] angle;
    logic [20:0] inl;
    logic [20:0] outl;
    logic [35:0] err;
    logic        fend;
  } shade_t;

  // Scoreboard: predicts colour, class, angle and frame totals per pixel request
  class angle_scoreboard;
    shade_t      shade_q[$];
    logic [15:0] cap;
    longint      inl_cnt, outl_cnt, err_sum;
    int          errors;
    longint      atan_deg[23];

    function void clear_state();
      cap = nmae_pkg::CAP_RESET;
      inl_cnt = 0;
      outl_cnt = 0;
      err_sum = 0;
      errors = 0;
      atan_deg = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                   14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};
    endfunction

    function longint unsigned int_root(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function logic [15:0] pair_angle(longint t0, longint t1, longint t2,
                                     longint g0, longint g1, longint g2);
      longint dot, cx, cy, cz, x, y, z, dx, dy, q;
      longint unsigned c2;
      dot = t0 * g0 + t1 * g1 + t2 * g2;
      cx = t1 * g2 - t2 * g1;
      cy = t2 * g0 - t0 * g2;
      cz = t0 * g1 - t1 * g0;
      c2 = cx * cx + cy * cy + cz * cz;
      x = (dot < 0 ? -dot : dot) * 8192;
      y = int_root(c2 << 26);
      z = 0;
      // vectoring rotation toward the x axis, accumulate degrees
      for (int i = 0; i < 23; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x += dx; y -= dy; z += atan_deg[i];
        end else if (y < 0) begin
          x -= dx; y += dy; z -= atan_deg[i];
        end
      end
      if (dot < 0) z = 64'sd180 * 65536 - z;
      if (z < 0) z = 0;
      q = (z + 128) >>> 8;
      if (q > 46080) q = 46080;
      return q[15:0];
    endfunction

    function void note_request(pair_t p);
      shade_t s;
      logic   no_t, no_g;
      longint v;
      s = '0;
      no_t = (p.tr | p.tg | p.tb) == 0;
      no_g = (p.gr | p.gg | p.gb) == 0;
      if (no_t && no_g) begin
        s.cls = nmae_pkg::CLS_BOTH_EMPTY; s.blue = 8'd255;
      end else if (no_t) begin
        s.cls = nmae_pkg::CLS_GUESS_ONLY; s.green = 8'd255;
      end else if (no_g) begin
        s.cls = nmae_pkg::CLS_TRUTH_ONLY; s.red = 8'd255;
        if (outl_cnt < PIXEL_SAT) outl_cnt++;
      end else begin
        s.angle = pair_angle(2 * longint'(p.tr) - 255, 2 * longint'(p.tg) - 255,
                             longint'(p.tb), 2 * longint'(p.gr) - 255,
                             2 * longint'(p.gg) - 255, longint'(p.gb));
        if (s.angle <= cap) begin
          s.cls = nmae_pkg::CLS_INLIER;
          if (inl_cnt < PIXEL_SAT) inl_cnt++;
          err_sum += s.angle;
          if (err_sum > SUM_SAT) err_sum = SUM_SAT;
        end else begin
          s.cls = nmae_pkg::CLS_OUTLIER;
          if (outl_cnt < PIXEL_SAT) outl_cnt++;
        end
        if (cap == 0) v = 255;
        else begin
          v = (255 * longint'(s.angle)) / longint'(cap);
          if (v > 255) v = 255;
        end
        s.red = v[7:0]; s.green = v[7:0]; s.blue = v[7:0];
      end
      s.inl = inl_cnt[20:0];
      s.outl = outl_cnt[20:0];
      s.err = err_sum[35:0];
      s.fend = p.last;
      if (p.last) begin
        inl_cnt = 0; outl_cnt = 0; err_sum = 0;
      end
      shade_q.push_back(s);
    endfunction

    function void check_result(shade_t a);
      shade_t e;
      if (shade_q.size() == 0) begin
        $error("unexpected result: no request pending");
        errors++;
        return;
      end
      e = shade_q.pop_front();
      if (a.red !== e.red) begin
        $error("pixel_red exp %0d got %0d", e.red, a.red); errors++;
      end
      if (a.green !== e.green) begin
        $error("pixel_green exp %0d got %0d", e.green, a.green); errors++;
      end
      if (a.blue !== e.blue) begin
        $error("pixel_blue exp %0d got %0d", e.blue, a.blue); errors++;
      end
      if (a.cls !== e.cls) begin
        $error("pixel_class exp %0d got %0d", e.cls, a.cls); errors++;
      end
      if (a.angle !== e.angle) begin
        $error("angle_deg_q8 exp %0d got %0d", e.angle, a.angle); errors++;
      end
      if (a.inl !== e.inl) begin
        $error("inlier_total exp %0d got %0d", e.inl, a.inl); errors++;
      end
      if (a.outl !== e.outl) begin
        $error("outlier_total exp %0d got %0d", e.outl, a.outl); errors++;
      end
      if (a.err !== e.err) begin
        $error("inlier_error_total exp %0d got %0d", e.err, a.err); errors++;
      end
      if (a.fend !== e.fend) begin
        $error("frame_end exp %0d got %0d", e.fend, a.fend); errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  int          tx_idle = 0;
  int          rx_idle = 0;
  bit          hold_start = 0;
  int          hold_len = 0;
  longint      cycles = 0;
  angle_scoreboard sb;

  nmae_in_if  in_if ();
  nmae_out_if out_if ();

  normal_map_angular_error u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_port   (in_if),
    .out_port  (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_start) begin
      hold_start = 0;
      hold_len <= 400;
      out_if.ready <= 1'b0;
    end else if (hold_len > 0) begin
      hold_len <= hold_len - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  // Check each accepted result
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result({out_if.pixel_red, out_if.pixel_green, out_if.pixel_blue,
                       out_if.pixel_class, out_if.angle_deg_q8, out_if.inlier_total,
                       out_if.outlier_total, out_if.inlier_error_total,
                       out_if.frame_end});
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_pair(pair_t p);
    in_if.valid <= 1'b1;
    in_if.truth_red <= p.tr;
    in_if.truth_green <= p.tg;
    in_if.truth_blue <= p.tb;
    in_if.guess_red <= p.gr;
    in_if.guess_green <= p.gg;
    in_if.guess_blue <= p.gb;
    in_if.last_pixel <= p.last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_request(p);
    // drop valid for a random gap
    if ($urandom_range(99) < tx_idle) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic go_idle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.shade_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cap(logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    sb.cap = v;
    cfg_we <= 1'b0;
  endtask

  function automatic pair_t rand_pair();
    pair_t p;
    int    k;
    p = pair_t'(49'({$urandom, $urandom}));
    p.last = ($urandom_range(24) == 0);
    k = $urandom_range(19);
    if (k == 0) {p.tr, p.tg, p.tb} = '0;
    else if (k == 1) {p.gr, p.gg, p.gb} = '0;
    else if (k == 2) begin
      {p.tr, p.tg, p.tb} = '0; {p.gr, p.gg, p.gb} = '0;
    end else if (k < 9) begin
      // near the truth, to land around the cap
      p.gr = p.tr + 8'($urandom_range(6)) - 8'd3;
      p.gg = p.tg + 8'($urandom_range(6)) - 8'd3;
      p.gb = p.tb + 8'($urandom_range(6)) - 8'd3;
    end
    return p;
  endfunction

  pair_t       directed[$];
  logic [15:0] caps[$];

  initial begin
    in_if.valid = 1'b0;
    {in_if.truth_red, in_if.truth_green, in_if.truth_blue} = '0;
    {in_if.guess_red, in_if.guess_green, in_if.guess_blue} = '0;
    in_if.last_pixel = 1'b0;
    sb = new();
    sb.clear_state();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empties, extremes, identical, right angle, near opposite
    directed = '{
      '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0},
      '{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 1'b0},
      '{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0},
      '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0},
      '{8'd128, 8'd128, 8'd255, 8'd128, 8'd128, 8'd255, 1'b0},
      '{8'd128, 8'd128, 8'd0, 8'd128, 8'd127, 8'd0, 1'b0},
      '{8'd0, 8'd127, 8'd0, 8'd255, 8'd128, 8'd0, 1'b0},
      '{8'd0, 8'd0, 8'd1, 8'd255, 8'd255, 8'd1, 1'b0},
      '{8'd128, 8'd128, 8'd255, 8'd140, 8'd128, 8'd255, 1'b0},
      '{8'd128, 8'd128, 8'd255, 8'd131, 8'd128, 8'd255, 1'b0},
      '{8'd1, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 1'b1},
      '{8'd200, 8'd30, 8'd90, 8'd10, 8'd220, 8'd40, 1'b0},
      '{8'd128, 8'd128, 8'd255, 8'd128, 8'd128, 8'd254, 1'b1}
    };
    foreach (directed[i]) send_pair(directed[i]);
    go_idle();

    // Random phases over cap settings, extremes included
    caps = '{16'd2560, 16'd0, 16'd65535, 16'd1, 16'd46080,
             16'($urandom_range(1, 46080)), 16'($urandom_range(1, 3000))};
    foreach (caps[c]) begin
      if (c < 3) begin
        tx_idle = 32; rx_idle = 83;
      end else if (c < 5) begin
        tx_idle = 83; rx_idle = 32;
      end else begin
        tx_idle = 0; rx_idle = 0;
      end
      write_cap(caps[c]);
      if (c == 5) hold_start = 1;
      // the hold-off phase offers more requests than the pipeline holds
      repeat ((c == 5) ? 100 : 56) send_pair(rand_pair());
      go_idle();
    end

    if (sb.errors == 0 && sb.shade_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* normal_map_angular_error.f */
rtl/core/nmae_pkg.sv
rtl/core/nmae_if.sv
rtl/core/nmae_front.sv
rtl/core/nmae_sqrt.sv
rtl/core/nmae_cordic.sv
rtl/core/nmae_grade.sv
rtl/core/normal_map_angular_error.sv
rtl/core/nmae_checker.sv
tb/tb_normal_map_angular_error.sv
